[sv/nta_pkg.sv]
package nta_pkg;

  localparam int unsigned NtaEntries = 10;
  localparam logic [31:0] TimeoutReset = 32'd15000;
  localparam logic CmdSweep = 1'b1;

  typedef enum logic [2:0] {
    EV_REFRESHED = 3'd0,
    EV_ADDED     = 3'd1,
    EV_FULL      = 3'd2,
    EV_REFUSED   = 3'd3,
    EV_REMOVED   = 3'd4,
    EV_DONE      = 3'd5
  } event_e;

  typedef enum logic [1:0] {
    A_REQ  = 2'd0,
    A_RD   = 2'd1,
    A_ZERO = 2'd2
  } addr_sel_e;

  typedef enum logic [1:0] {
    SL_ZERO = 2'd0,
    SL_RD   = 2'd1,
    SL_FREE = 2'd2
  } slot_sel_e;

  typedef enum logic [1:0] {
    WR_NONE = 2'd0,
    WR_ADD  = 2'd1,
    WR_SEEN = 2'd2,
    WR_CLR  = 2'd3
  } wr_e;

  typedef enum logic [3:0] {
    C_NEVER   = 4'd0,
    C_ALWAYS  = 4'd1,
    C_NO_REQ  = 4'd2,
    C_SWEEP   = 4'd3,
    C_HIT     = 4'd4,
    C_MORE    = 4'd5,
    C_NO_FREE = 4'd6,
    C_NO_OK   = 4'd7,
    C_KEEP    = 4'd8
  } cond_e;

  typedef struct packed {
    logic      take_in;
    logic      rd;
    logic      inc;
    logic      track_free;
    logic      emit;
    event_e    ev;
    addr_sel_e addr_sel;
    slot_sel_e slot_sel;
    logic      last;
    wr_e       wr;
    cond_e     cond;
    logic [3:0] tgt;
  } ctrl_t;

  typedef struct packed {
    logic hit;
    logic keep;
    logic more;
    logic no_free;
    logic no_ok;
    logic sweep;
    logic out_busy;
  } stat_t;

  // Step numbers of the control program.
  localparam logic [3:0] StIdle    = 4'd0;
  localparam logic [3:0] StDisp    = 4'd1;
  localparam logic [3:0] StSgRd    = 4'd2;
  localparam logic [3:0] StSgEval  = 4'd3;
  localparam logic [3:0] StSgNext  = 4'd4;
  localparam logic [3:0] StSgDec   = 4'd5;
  localparam logic [3:0] StSgChk   = 4'd6;
  localparam logic [3:0] StSgAdd   = 4'd7;
  localparam logic [3:0] StSgFull  = 4'd8;
  localparam logic [3:0] StSgRef   = 4'd9;
  localparam logic [3:0] StSgHit   = 4'd10;
  localparam logic [3:0] StSwRd    = 4'd11;
  localparam logic [3:0] StSwEval  = 4'd12;
  localparam logic [3:0] StSwRem   = 4'd13;
  localparam logic [3:0] StSwNext  = 4'd14;
  localparam logic [3:0] StSwDone  = 4'd15;

  function automatic ctrl_t nta_rom(input logic [3:0] step);
    ctrl_t w;
    w = '0;
    case (step)
      StIdle: begin
        w.take_in = 1'b1;
        w.cond    = C_NO_REQ;
        w.tgt     = StIdle;
      end
      StDisp: begin
        w.cond = C_SWEEP;
        w.tgt  = StSwRd;
      end
      StSgRd: begin
        w.rd = 1'b1;
      end
      StSgEval: begin
        w.track_free = 1'b1;
        w.cond       = C_HIT;
        w.tgt        = StSgHit;
      end
      StSgNext: begin
        w.inc  = 1'b1;
        w.cond = C_MORE;
        w.tgt  = StSgRd;
      end
      StSgDec: begin
        w.cond = C_NO_FREE;
        w.tgt  = StSgFull;
      end
      StSgChk: begin
        w.cond = C_NO_OK;
        w.tgt  = StSgRef;
      end
      StSgAdd: begin
        w.emit     = 1'b1;
        w.ev       = EV_ADDED;
        w.addr_sel = A_REQ;
        w.slot_sel = SL_FREE;
        w.last     = 1'b1;
        w.wr       = WR_ADD;
        w.cond     = C_ALWAYS;
        w.tgt      = StIdle;
      end
      StSgFull: begin
        w.emit     = 1'b1;
        w.ev       = EV_FULL;
        w.addr_sel = A_REQ;
        w.slot_sel = SL_ZERO;
        w.last     = 1'b1;
        w.cond     = C_ALWAYS;
        w.tgt      = StIdle;
      end
      StSgRef: begin
        w.emit     = 1'b1;
        w.ev       = EV_REFUSED;
        w.addr_sel = A_REQ;
        w.slot_sel = SL_ZERO;
        w.last     = 1'b1;
        w.cond     = C_ALWAYS;
        w.tgt      = StIdle;
      end
      StSgHit: begin
        w.emit     = 1'b1;
        w.ev       = EV_REFRESHED;
        w.addr_sel = A_REQ;
        w.slot_sel = SL_RD;
        w.last     = 1'b1;
        w.wr       = WR_SEEN;
        w.cond     = C_ALWAYS;
        w.tgt      = StIdle;
      end
      StSwRd: begin
        w.rd = 1'b1;
      end
      StSwEval: begin
        w.cond = C_KEEP;
        w.tgt  = StSwNext;
      end
      StSwRem: begin
        w.emit     = 1'b1;
        w.ev       = EV_REMOVED;
        w.addr_sel = A_RD;
        w.slot_sel = SL_RD;
        w.wr       = WR_CLR;
      end
      StSwNext: begin
        w.inc  = 1'b1;
        w.cond = C_MORE;
        w.tgt  = StSwRd;
      end
      StSwDone: begin
        w.emit     = 1'b1;
        w.ev       = EV_DONE;
        w.addr_sel = A_ZERO;
        w.slot_sel = SL_ZERO;
        w.last     = 1'b1;
        w.cond     = C_ALWAYS;
        w.tgt      = StIdle;
      end
      default: begin
        w.cond = C_ALWAYS;
        w.tgt  = StIdle;
      end
    endcase
    return w;
  endfunction

endpackage

[sv/nta_seq.sv]
module nta_seq
  import nta_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  input  stat_t stat_i,
  output ctrl_t ctrl_o
);

  logic [3:0] upc_q, upc_d;
  ctrl_t      word;
  logic       hold;
  logic       cond_true;

  assign word = nta_rom(upc_q);

  // An emitting step waits in place while the output register is still full.
  assign hold = word.emit && stat_i.out_busy;

  always_comb begin
    case (word.cond)
      C_NEVER:   cond_true = 1'b0;
      C_ALWAYS:  cond_true = 1'b1;
      C_NO_REQ:  cond_true = !in_valid_i;
      C_SWEEP:   cond_true = stat_i.sweep;
      C_HIT:     cond_true = stat_i.hit;
      C_MORE:    cond_true = stat_i.more;
      C_NO_FREE: cond_true = stat_i.no_free;
      C_NO_OK:   cond_true = stat_i.no_ok;
      C_KEEP:    cond_true = stat_i.keep;
      default:   cond_true = 1'b0;
    endcase
  end

  always_comb begin
    if (hold) begin
      upc_d = upc_q;
    end else if (cond_true) begin
      upc_d = word.tgt;
    end else begin
      upc_d = upc_q + 4'd1;
    end
  end

  always_comb begin
    ctrl_o = word;
    if (hold) begin
      ctrl_o.emit = 1'b0;
      ctrl_o.wr   = WR_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= StIdle;
    end else begin
      upc_q <= upc_d;
    end
  end

endmodule

[sv/nta_dpath.sv]
module nta_dpath
  import nta_pkg::*;
#(
  parameter int unsigned ENTRIES = NtaEntries
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  ctrl_t       ctrl_i,
  input  logic        in_acc_i,
  input  logic        cmd_i,
  input  logic [15:0] address_i,
  input  logic [31:0] now_ms_i,
  input  logic        radio_ok_i,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_timeout_ms_i,
  input  logic        out_stall_i,
  output logic        out_valid_o,
  output logic [2:0]  event_res_o,
  output logic [15:0] entry_address_o,
  output logic [3:0]  slot_o,
  output logic        last_o,
  output stat_t       stat_o
);

  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  logic [31:0]  timeout_q;
  logic         cmd_q;
  logic [15:0]  addr_q;
  logic [31:0]  now_q;
  logic         ok_q;
  logic [IW-1:0] idx_q;
  logic [IW-1:0] rd_idx_q;
  logic          rd_vld_q;
  logic [15:0]   rd_addr_q;
  logic [31:0]   rd_seen_q;
  logic          free_found_q;
  logic [IW-1:0] free_slot_q;
  logic [ENTRIES-1:0] valid_q;

  logic [15:0] addr_mem [ENTRIES];
  logic [31:0] seen_mem [ENTRIES];

  logic          out_vld_q;
  event_e        ev_q;
  logic [15:0]   oaddr_q;
  logic [3:0]    oslot_q;
  logic          olast_q;

  logic [31:0]   age;
  logic [IW+3:0] rd_idx_ext;
  logic [IW+3:0] free_ext;
  logic [15:0]   sel_addr;
  logic [3:0]    sel_slot;

  assign rd_idx_ext = {4'b0, rd_idx_q};
  assign free_ext   = {4'b0, free_slot_q};

  always_comb begin
    case (ctrl_i.addr_sel)
      A_REQ:   sel_addr = addr_q;
      A_RD:    sel_addr = rd_addr_q;
      default: sel_addr = '0;
    endcase
    case (ctrl_i.slot_sel)
      SL_RD:   sel_slot = rd_idx_ext[3:0];
      SL_FREE: sel_slot = free_ext[3:0];
      default: sel_slot = '0;
    endcase
  end

  // Wrapping age of the entry that was read last.
  assign age = now_q - rd_seen_q;

  assign stat_o.hit      = rd_vld_q && (rd_addr_q == addr_q);
  assign stat_o.keep     = !(rd_vld_q && (age > timeout_q));
  assign stat_o.more     = (idx_q != IW'(ENTRIES - 1));
  assign stat_o.no_free  = !free_found_q;
  assign stat_o.no_ok    = !ok_q;
  assign stat_o.sweep    = (cmd_q == CmdSweep);
  assign stat_o.out_busy = out_vld_q && out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q    <= TimeoutReset;
      idx_q        <= '0;
      free_found_q <= 1'b0;
      valid_q      <= '0;
      out_vld_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        timeout_q <= cfg_timeout_ms_i;
      end
      if (in_acc_i) begin
        idx_q        <= '0;
        free_found_q <= 1'b0;
      end else if (ctrl_i.inc) begin
        idx_q <= idx_q + 1'b1;
      end
      if (ctrl_i.track_free && !rd_vld_q && !free_found_q) begin
        free_found_q <= 1'b1;
      end
      case (ctrl_i.wr)
        WR_ADD:  valid_q[free_slot_q] <= 1'b1;
        WR_CLR:  valid_q[rd_idx_q] <= 1'b0;
        default: ;
      endcase
      if (ctrl_i.emit) begin
        out_vld_q <= 1'b1;
      end else if (out_vld_q && !out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc_i) begin
      cmd_q  <= cmd_i;
      addr_q <= address_i;
      now_q  <= now_ms_i;
      ok_q   <= radio_ok_i;
    end
    if (ctrl_i.rd) begin
      rd_idx_q <= idx_q;
      rd_vld_q <= valid_q[idx_q];
    end
    if (ctrl_i.track_free && !rd_vld_q && !free_found_q) begin
      free_slot_q <= rd_idx_q;
    end
    if (ctrl_i.emit) begin
      ev_q    <= ctrl_i.ev;
      oaddr_q <= sel_addr;
      oslot_q <= sel_slot;
      olast_q <= ctrl_i.last;
    end
  end

  // Address and timestamp store: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    case (ctrl_i.wr)
      WR_ADD: begin
        addr_mem[free_slot_q] <= addr_q;
        seen_mem[free_slot_q] <= now_q;
      end
      WR_SEEN: seen_mem[rd_idx_q] <= now_q;
      default: ;
    endcase
    if (ctrl_i.rd) begin
      rd_addr_q <= addr_mem[idx_q];
      rd_seen_q <= seen_mem[idx_q];
    end
  end

  assign out_valid_o     = out_vld_q;
  assign event_res_o     = ev_q;
  assign entry_address_o = oaddr_q;
  assign slot_o          = oslot_q;
  assign last_o          = olast_q;

endmodule

[sv/neighbor_table_with_aging.sv]
// A refresh of slot i gives its result as soon as the scan has read slot i; a full table,
// an add or a refusal is decided only after every entry has been read.
// A sweep reads every entry, gives a removal result for each expired one, then its done result.
// Throughput: one request at a time; the next is taken only once the control is back in idle,
// after the last result is registered, and an emitting step waits while a result is stalled.
// Reset clears all valid marks at once and loads the timeout with 15000 ms.
module neighbor_table_with_aging
  import nta_pkg::*;
#(
  parameter int unsigned ENTRIES = NtaEntries
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        cmd_i,
  input  logic [15:0] address_i,
  input  logic [31:0] now_ms_i,
  input  logic        radio_ok_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_timeout_ms_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  event_res_o,
  output logic [15:0] entry_address_o,
  output logic [3:0]  slot_o,
  output logic        last_o
);

  ctrl_t ctrl;
  stat_t stat;
  logic  in_acc;

  assign in_stall_o  = !ctrl.take_in;
  assign in_acc      = in_valid_i && ctrl.take_in;
  assign cfg_ready_o = 1'b1;

  nta_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  nta_dpath #(
    .ENTRIES (ENTRIES)
  ) u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .ctrl_i           (ctrl),
    .in_acc_i         (in_acc),
    .cmd_i            (cmd_i),
    .address_i        (address_i),
    .now_ms_i         (now_ms_i),
    .radio_ok_i       (radio_ok_i),
    .cfg_we_i         (cfg_valid_i && cfg_ready_o),
    .cfg_timeout_ms_i (cfg_timeout_ms_i),
    .out_stall_i      (out_stall_i),
    .out_valid_o      (out_valid_o),
    .event_res_o      (event_res_o),
    .entry_address_o  (entry_address_o),
    .slot_o           (slot_o),
    .last_o           (last_o),
    .stat_o           (stat)
  );

  // Only one request is in work, so an accepted request stalls the next one.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request accepted while another is in work");

  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (event_res_o == EV_DONE) |-> last_o && (slot_o == 4'd0)
      && (entry_address_o == 16'd0))
    else $error("sweep done result malformed");

  a_removed_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (event_res_o == EV_REMOVED) |-> !last_o)
    else $error("removal result marked as last");

  a_stall_until_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> in_stall_o)
    else $error("request taken before the last result of the previous one");

endmodule
